>>> rtl/alst_pkg.sv
// Package for the address lock slot table.
// Holds the operation and status codes, the controller state type and the default size.
// No dependencies.
package alst_pkg;

    localparam int SLOTS_DEFAULT = 256;

    localparam int KEY_W    = 64;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 8;

    localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NULLKEY  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLEAR = 5'b00010,
        S_HASH  = 5'b00100,
        S_READ  = 5'b01000,
        S_CHECK = 5'b10000
    } state_t;

endpackage

>>> rtl/address_lock_slot_table.sv
// Address lock slot table: open-addressed table of 64-bit keys with linear probing.
// One synchronous memory holds a used bit and a key per slot.
// Depends on alst_pkg.
//
//  channel   signals                          direction  handshake
//  request   start, opcode, key_address       in         taken when start high and busy low
//  result    done, status, slot_index         out        done high for one cycle per request
//
// A null key or unused opcode answers in the cycle after the request is taken.
// An acquire or release keeps busy high through the hash state (one byte of the hash at a time
// when TABLE_SLOTS is not a power of two), then a memory read and a compare per slot probed,
// from the home slot up to all TABLE_SLOTS slots for a complete probe; the result
// follows in the next cycle.
// A clear op sweeps the memory one slot a cycle, through every slot; the same sweep runs
// after reset, during which busy is high. The result side cannot stall.
module address_lock_slot_table
    import alst_pkg::*;
#(
    parameter int TABLE_SLOTS = SLOTS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     opcode,
    input  logic [KEY_W-1:0]    key_address,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [SLOT_W-1:0]   slot_index
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam bit IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [IDX_W:0]   SLOTS_W1 = (IDX_W + 1)'(TABLE_SLOTS);
    localparam int HASH_STEPS = 8;
    localparam int HCNT_W = $clog2(KEY_W / HASH_STEPS);
    localparam logic [HCNT_W-1:0] HCNT_LAST = HCNT_W'(KEY_W / HASH_STEPS - 1);

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     cnt_reg, cnt_next;
    logic [HCNT_W-1:0]    hcnt_reg, hcnt_next;
    logic                 clr_report_reg, clr_report_next;
    logic                 acq_reg, acq_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic                 done_reg, done_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;

    logic [KEY_W:0]       slot_mem [TABLE_SLOTS];
    logic [KEY_W:0]       rd_data_reg;
    logic                 mem_we;
    logic [KEY_W:0]       mem_wdata;

    logic [KEY_W-1:0]     hash_val;
    logic [IDX_W-1:0]     rem_step;
    logic [IDX_W-1:0]     idx_inc;
    logic                 accept;
    logic                 rd_used;
    logic                 rd_match;

    assign accept   = start && !busy;
    assign hash_val = (key_reg >> 3) ^ (key_reg >> 7) ^ (key_reg >> 11);
    assign idx_inc  = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign rd_used  = rd_data_reg[KEY_W];
    assign rd_match = (rd_data_reg[KEY_W-1:0] == key_reg);

    // Remainder by TABLE_SLOTS, one byte of the hash per cycle, most significant first.
    always_comb
    begin
        logic [IDX_W:0] t;
        logic [5:0]     base;
        rem_step = idx_reg;
        base = {~hcnt_reg, 3'b000};
        for (int i = HASH_STEPS - 1; i >= 0; i--)
        begin
            t = {rem_step, hash_val[base + 6'(i)]};
            if (t >= SLOTS_W1)
            begin
                t = t - SLOTS_W1;
            end
            rem_step = t[IDX_W-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        hcnt_next       = hcnt_reg;
        clr_report_next = clr_report_reg;
        acq_next        = acq_reg;
        key_next        = key_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        slot_next       = slot_reg;
        mem_we          = 1'b0;
        mem_wdata       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next  = key_address;
                    acq_next  = (opcode == OP_ACQUIRE);
                    idx_next  = '0;
                    cnt_next  = '0;
                    hcnt_next = '0;
                    if (opcode == OP_CLEAR)
                    begin
                        clr_report_next = 1'b1;
                        state_next      = S_CLEAR;
                    end
                    else if (opcode == OP_UNUSED)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_NOTFOUND;
                        slot_next   = '0;
                    end
                    else if (key_address == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_NULLKEY;
                        slot_next   = '0;
                    end
                    else
                    begin
                        state_next = S_HASH;
                    end
                end
            end
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next        = '0;
                    state_next      = S_IDLE;
                    clr_report_next = 1'b0;
                    if (clr_report_reg)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_CLEARED;
                        slot_next   = '0;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_HASH:
            begin
                if (IS_POW2)
                begin
                    idx_next   = hash_val[IDX_W-1:0];
                    state_next = S_READ;
                end
                else
                begin
                    idx_next  = rem_step;
                    hcnt_next = hcnt_reg + 1'b1;
                    if (hcnt_reg == HCNT_LAST)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (rd_used && rd_match)
                begin
                    done_next   = 1'b1;
                    status_next = ST_FOUND;
                    slot_next   = SLOT_W'(idx_reg);
                    state_next  = S_IDLE;
                end
                else if (!rd_used)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (acq_reg)
                    begin
                        mem_we      = 1'b1;
                        mem_wdata   = {1'b1, key_reg};
                        status_next = ST_INSERTED;
                        slot_next   = SLOT_W'(idx_reg);
                    end
                    else
                    begin
                        status_next = ST_NOTFOUND;
                        slot_next   = '0;
                    end
                end
                else if (cnt_reg == LAST_IDX)
                begin
                    done_next   = 1'b1;
                    status_next = acq_reg ? ST_FULL : ST_NOTFOUND;
                    slot_next   = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    idx_next   = idx_inc;
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Slot memory: one write port and one registered read port, both at the slot pointer.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[idx_reg] <= mem_wdata;
        end
        rd_data_reg <= slot_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        acq_reg <= acq_next;
    end

    // Reset starts a sweep that marks every slot unused.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            hcnt_reg       <= '0;
            clr_report_reg <= 1'b0;
            done_reg       <= 1'b0;
            status_reg     <= ST_FOUND;
            slot_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            hcnt_reg       <= hcnt_next;
            clr_report_reg <= clr_report_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            slot_reg       <= slot_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign slot_index = slot_reg;

    // A result is only ever given as the controller returns to idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result given while controller busy");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (status_reg <= ST_CLEARED))
        else $error("status code out of range");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_FOUND && status_reg != ST_INSERTED)
            |-> (slot_reg == '0))
        else $error("slot index set on a result without a slot");

    // Every request taken either answers at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done_reg))
        else $error("request taken without progress");

endmodule

>>> tb/sv/address_lock_slot_table_tb.sv
// Self-checking testbench for the address lock slot table.
// Drives acquire, release, clear and unused-opcode requests and checks every result against a shadow table.
// Depends on alst_pkg and address_lock_slot_table.
`timescale 1ns / 1ps

module address_lock_slot_table_tb;
    import alst_pkg::*;

    localparam int SLOTS          = SLOTS_DEFAULT;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DIRECTED_N     = 21;
    localparam int POOL_N         = 32;
    localparam int RANDOM_PER_PHASE = 357;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } lock_result_t;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [KEY_W-1:0]    key;
        logic                typed;
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } directed_req_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     opcode;
    logic [KEY_W-1:0]    key_address;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;

    lock_result_t     expected_results[$];
    logic [KEY_W-1:0] shadow_key [SLOTS];
    bit               shadow_used [SLOTS];
    logic [KEY_W-1:0] key_pool [POOL_N];
    logic [18:0]      hot_low [4];

    int          failures      = 0;
    int          requests_taken = 0;
    int          idle_cycles   = 0;
    int unsigned idle_pct      = 0;

    // Rows with typed set carry a result that follows directly from the table contents.
    directed_req_t directed_reqs [DIRECTED_N] = '{
        '{OP_RELEASE, 64'h0000_0000_0000_1000, 1'b1, ST_NOTFOUND, 8'd0},
        '{OP_ACQUIRE, 64'h0000_0000_0000_0000, 1'b1, ST_NULLKEY,  8'd0},
        '{OP_RELEASE, 64'h0000_0000_0000_0000, 1'b1, ST_NULLKEY,  8'd0},
        '{OP_UNUSED,  64'h0123_4567_89AB_CDEF, 1'b1, ST_NOTFOUND, 8'd0},
        '{OP_ACQUIRE, 64'h0000_0000_0000_0008, 1'b1, ST_INSERTED, 8'd1},
        '{OP_ACQUIRE, 64'h0000_0000_0000_0008, 1'b1, ST_FOUND,    8'd1},
        '{OP_RELEASE, 64'h0000_0000_0000_0008, 1'b1, ST_FOUND,    8'd1},
        '{OP_ACQUIRE, 64'h0000_0000_0010_0008, 1'b0, ST_FOUND,    8'd0},
        '{OP_RELEASE, 64'h0000_0000_0010_0008, 1'b0, ST_FOUND,    8'd0},
        '{OP_ACQUIRE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_FOUND,    8'd0},
        '{OP_ACQUIRE, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, ST_FOUND,    8'd0},
        '{OP_RELEASE, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, ST_FOUND,    8'd0},
        '{OP_RELEASE, 64'h3FFF_FFFF_FFFF_FFFF, 1'b0, ST_FOUND,    8'd0},
        '{OP_ACQUIRE, 64'h8000_0000_0000_0000, 1'b0, ST_FOUND,    8'd0},
        '{OP_CLEAR,   64'h0000_0000_0000_0000, 1'b1, ST_CLEARED,  8'd0},
        '{OP_CLEAR,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_CLEARED,  8'd0},
        '{OP_RELEASE, 64'h0000_0000_0000_0008, 1'b1, ST_NOTFOUND, 8'd0},
        '{OP_ACQUIRE, 64'h0000_0000_0000_0001, 1'b0, ST_FOUND,    8'd0},
        '{OP_UNUSED,  64'h0000_0000_0000_0000, 1'b1, ST_NOTFOUND, 8'd0},
        '{OP_ACQUIRE, 64'h0000_0000_0000_0008, 1'b0, ST_FOUND,    8'd0},
        '{OP_CLEAR,   64'h0000_0000_0000_1234, 1'b1, ST_CLEARED,  8'd0}
    };

    address_lock_slot_table #(
        .TABLE_SLOTS(SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .key_address(key_address),
        .done(done),
        .status(status),
        .slot_index(slot_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Applies one request to the shadow table and returns the result it should give.
    function automatic lock_result_t predict_lock_result(logic [OP_W-1:0] op,
                                                         logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] mix;
        int unsigned      idx;
        lock_result_t     res;
        res.status = ST_NOTFOUND;
        res.slot   = '0;
        if (op == OP_CLEAR)
        begin
            foreach (shadow_used[i])
                shadow_used[i] = 1'b0;
            res.status = ST_CLEARED;
            return res;
        end
        if (op == OP_UNUSED)
            return res;
        if (key == '0)
        begin
            res.status = ST_NULLKEY;
            return res;
        end
        mix = (key >> 3) ^ (key >> 7) ^ (key >> 11);
        idx = 32'(mix % SLOTS);
        for (int n = 0; n < SLOTS; n++)
        begin
            if (shadow_used[idx] && shadow_key[idx] == key)
            begin
                res.status = ST_FOUND;
                res.slot   = idx[SLOT_W-1:0];
                return res;
            end
            if (!shadow_used[idx])
            begin
                if (op == OP_ACQUIRE)
                begin
                    shadow_key[idx]  = key;
                    shadow_used[idx] = 1'b1;
                    res.status = ST_INSERTED;
                    res.slot   = idx[SLOT_W-1:0];
                end
                return res;
            end
            idx = (idx + 1) % SLOTS;
        end
        // A complete probe with neither a match nor a free slot.
        if (op == OP_ACQUIRE)
            res.status = ST_FULL;
        return res;
    endfunction

    // Called just after a falling edge; returns just after the falling edge that follows
    // the acceptance, so that start can stay high into the next request.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        opcode      <= op;
        key_address <= key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : result_monitor
        lock_result_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                want = predict_lock_result(opcode, key_address);
                if (requests_taken < DIRECTED_N && directed_reqs[requests_taken].typed)
                begin
                    want.status = directed_reqs[requests_taken].status;
                    want.slot   = directed_reqs[requests_taken].slot;
                end
                expected_results.push_back(want);
                requests_taken++;
            end
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request pending: status %0d slot_index %0d",
                           status, slot_index);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        failures++;
                    end
                    if (slot_index !== want.slot)
                    begin
                        $error("slot_index: expected %0d, actual %0d", want.slot, slot_index);
                        failures++;
                    end
                end
            end
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
    end

    initial
    begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("address_lock_slot_table: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned      pick;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] spare;
        start       = 1'b0;
        opcode      = OP_ACQUIRE;
        key_address = '0;
        rst_n       = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_reqs[i])
            send_request(directed_reqs[i].op, directed_reqs[i].key);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: idle_pct = 0;
                1: idle_pct = 79;
                default: idle_pct = 29;
            endcase

            // Fill the table completely, then probe it end to end for misses.
            send_request(OP_CLEAR, {$urandom, $urandom});
            repeat (SLOTS) send_request(OP_ACQUIRE, {$urandom, $urandom});
            repeat (6) send_request(OP_ACQUIRE, {$urandom, $urandom});
            repeat (6) send_request(OP_RELEASE, {$urandom, $urandom});
            send_request(OP_CLEAR, {$urandom, $urandom});

            // Keys that share their low 19 bits share a home slot, so the pool forces
            // probe chains and wrap-around.
            foreach (hot_low[i])
                hot_low[i] = 19'($urandom);
            foreach (key_pool[i])
            begin
                k = {$urandom, $urandom};
                if ($urandom_range(2) != 0)
                    k[18:0] = hot_low[$urandom_range(3)];
                key_pool[i] = k;
            end

            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                pick  = $urandom_range(99);
                k     = key_pool[$urandom_range(POOL_N - 1)];
                spare = {$urandom, $urandom};
                if (pick < 45)
                    send_request(OP_ACQUIRE, k);
                else if (pick < 75)
                    send_request(OP_RELEASE, k);
                else if (pick < 82)
                    send_request(OP_ACQUIRE, spare);
                else if (pick < 88)
                    send_request(OP_RELEASE, spare);
                else if (pick < 92)
                    send_request(pick[0] ? OP_RELEASE : OP_ACQUIRE, '0);
                else if (pick < 95)
                    send_request(OP_UNUSED, spare);
                else if (pick < 97)
                    send_request(OP_CLEAR, spare);
                else
                    send_request(OP_ACQUIRE, {spare[KEY_W-1:19], k[18:0]});
            end
        end

        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (failures == 0 && expected_results.size() == 0)
            $display("address_lock_slot_table: match");
        else
            $display("address_lock_slot_table: mismatch");
        $finish;
    end

endmodule

>>> sim.f
rtl/alst_pkg.sv
rtl/address_lock_slot_table.sv
tb/sv/address_lock_slot_table_tb.sv
